// ===== hw/rtl/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Shared types and codes for the framed packet receiver with checksum.
// ----------------------------------------------------------------------------
package fpr_pkg;

  // Parser phase codes.
  localparam logic [2:0] PH_WAIT  = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_DATA  = 3'd2;
  localparam logic [2:0] PH_CHECK = 3'd3;
  localparam logic [2:0] PH_END   = 3'd4;

  // Frame outcome codes. A good frame means the host should answer with ACK (0x06).
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_GOOD    = 2'd1;
  localparam logic [1:0] ST_BAD_END = 2'd2;
  localparam logic [1:0] ST_BAD_SUM = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

  // Reset values of the markers.
  localparam logic [7:0] START_MARKER_RST = 8'h02;
  localparam logic [7:0] END_MARKER_RST   = 8'h03;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       payload_valid;
    logic [1:0] frame_status;
    logic [7:0] frame_length;
  } result_t;

endpackage

// ===== hw/rtl/fpr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Framed packet receiver configuration registers
// Holds the start and end marker values written through the write port.
// ----------------------------------------------------------------------------
module fpr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output fpr_pkg::cfg_t                 cfg
);
  import fpr_pkg::*;

  // Decode the register index; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= START_MARKER_RST;
      cfg.end_marker   <= END_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_MARKER: cfg.start_marker <= cfg_data;
        CFG_END_MARKER:   cfg.end_marker   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/fpr_in_reg.sv =====
// ----------------------------------------------------------------------------
// Framed packet receiver input register
// Registers each incoming byte beat and hands it to the parser.
// ----------------------------------------------------------------------------
module fpr_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       held_valid,
  output logic [7:0] held_byte,
  input  logic       take
);

  // The register is free when empty or when its beat moves on this cycle.
  assign rx_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx_ready) begin
      held_valid <= rx_valid;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ===== hw/rtl/fpr_parse.sv =====
// ----------------------------------------------------------------------------
// Framed packet receiver parser
// Frame state machine, running checksum and result formation for one byte.
// ----------------------------------------------------------------------------
module fpr_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_in,
  input  fpr_pkg::cfg_t    cfg,
  output fpr_pkg::result_t res
);
  import fpr_pkg::*;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [7:0] length_held;
  logic [7:0] length_held_next;
  logic [7:0] data_position;
  logic [7:0] data_position_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] check_byte_held;
  logic [7:0] check_byte_held_next;

  // Next state and result for the byte at the parser input.
  always_comb begin
    phase_next           = phase;
    length_held_next     = length_held;
    data_position_next   = data_position;
    running_sum_next     = running_sum;
    check_byte_held_next = check_byte_held;
    res                  = '0;
    unique case (phase)
      PH_LEN: begin
        length_held_next   = byte_in;
        data_position_next = 8'd0;
        running_sum_next   = 8'd0;
        phase_next         = (byte_in == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        res.payload_byte   = byte_in;
        res.payload_index  = data_position;
        res.payload_valid  = 1'b1;
        running_sum_next   = running_sum + byte_in;
        data_position_next = data_position + 8'd1;
        if (data_position_next == length_held) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        check_byte_held_next = byte_in;
        phase_next           = PH_END;
      end
      PH_END: begin
        if (byte_in != cfg.end_marker) begin
          res.frame_status = ST_BAD_END;
        end else if (running_sum != check_byte_held) begin
          res.frame_status = ST_BAD_SUM;
        end else begin
          res.frame_status = ST_GOOD;
        end
        res.frame_length = length_held;
        phase_next       = PH_WAIT;
      end
      default: begin
        // Waiting for a frame; unused codes behave the same way.
        phase_next = (byte_in == cfg.start_marker) ? PH_LEN : PH_WAIT;
      end
    endcase
  end

  // State registers advance once per processed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      length_held     <= 8'd0;
      data_position   <= 8'd0;
      running_sum     <= 8'd0;
      check_byte_held <= 8'd0;
    end else if (step) begin
      phase           <= phase_next;
      length_held     <= length_held_next;
      data_position   <= data_position_next;
      running_sum     <= running_sum_next;
      check_byte_held <= check_byte_held_next;
    end
  end

`ifndef NO_ASSERTIONS
  // The frame state never moves without a beat.
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(running_sum) && $stable(data_position))
    else $error("parser state changed without a beat");

  // While collecting data, the position stays below the frame length.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (data_position < length_held))
    else $error("data position reached frame length in data phase");

  // The last data byte leads to the checksum byte.
  a_last_data: assert property (@(posedge clk) disable iff (rst)
    step && (phase == PH_DATA) && (data_position + 8'd1 == length_held)
    |=> (phase == PH_CHECK))
    else $error("last data byte did not lead to checksum phase");

  // A frame end always reports an outcome and returns to waiting.
  a_end: assert property (@(posedge clk) disable iff (rst)
    step && (phase == PH_END) |-> (res.frame_status != ST_NONE) ##1 (phase == PH_WAIT))
    else $error("frame end handled wrongly");
`endif

endmodule

// ===== hw/rtl/fpr_out_reg.sv =====
// ----------------------------------------------------------------------------
// Framed packet receiver result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module fpr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  input  fpr_pkg::result_t load_res,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output fpr_pkg::result_t res
);
  import fpr_pkg::*;

  // Free when empty or when the held beat is being taken.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      res <= load_res;
    end
  end

endmodule

// ===== hw/rtl/framed_packet_receiver_checksum_top.sv =====
// ----------------------------------------------------------------------------
// Framed packet receiver with checksum
// Parses start marker, length, data, checksum and end marker frames.
// ----------------------------------------------------------------------------
// The block takes one byte beat per clock while results are taken, and returns
// exactly one result beat per input beat: each byte is held in the input
// register, passes the frame parser, and its result is held in the result
// register. The parser is a single 8-bit compare and add, so a new byte is
// accepted every cycle as long as results are taken. While a result waits to
// be taken, one more byte is accepted into the input register and then the
// input stalls until the result leaves.
// Data bytes come out with their index; on the end marker position the block
// reports good (send ACK 0x06), bad end marker, or checksum mismatch, with the
// frame length. The user must write markers through the cfg port (index 0
// start marker, index 1 end marker) while idle; the block does not enforce it.
module framed_packet_receiver_checksum_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          rx_valid,
  output logic                          rx_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    payload_byte,
  output logic [7:0]                    payload_index,
  output logic                          payload_valid,
  output logic [1:0]                    frame_status,
  output logic [7:0]                    frame_length
);
  import fpr_pkg::*;

  cfg_t       cfg;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       can_load;
  logic       step;
  result_t    step_res;
  result_t    out_res;

  // A beat is processed when it sits in the input register and the result
  // register can take its result.
  assign step = held_valid && can_load;

  fpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .take       (can_load)
  );

  fpr_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (held_byte),
    .cfg     (cfg),
    .res     (step_res)
  );

  fpr_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held_valid),
    .load_res   (step_res),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (out_res)
  );

  assign payload_byte  = out_res.payload_byte;
  assign payload_index = out_res.payload_index;
  assign payload_valid = out_res.payload_valid;
  assign frame_status  = out_res.frame_status;
  assign frame_length  = out_res.frame_length;

endmodule

// ===== tb/sv/fpr_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet receiver scoreboard
// Tracks the frame parser state for every accepted byte and checks each
// result beat, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package fpr_scoreboard_pkg;

  import fpr_pkg::*;

  class frame_scoreboard;

    // Marker registers as currently programmed.
    logic [7:0] start_marker;
    logic [7:0] end_marker;

    // Parser state, mirrored byte for byte.
    logic [2:0] parse_phase;
    logic [7:0] frame_len;
    logic [7:0] data_pos;
    logic [7:0] data_sum;
    logic [7:0] check_byte;

    result_t     expected_q[$];
    int unsigned bytes_noted;
    int unsigned results_seen;
    int unsigned mismatches;

    function new();
      start_marker = START_MARKER_RST;
      end_marker   = END_MARKER_RST;
      parse_phase  = PH_WAIT;
      frame_len    = '0;
      data_pos     = '0;
      data_sum     = '0;
      check_byte   = '0;
      bytes_noted  = 0;
      results_seen = 0;
      mismatches   = 0;
    endfunction

    // Mirror a register write; indexes past the end marker have no effect.
    function void set_marker(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      if (idx == CFG_START_MARKER) begin
        start_marker = value;
      end else if (idx == CFG_END_MARKER) begin
        end_marker = value;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advance the parser by one accepted byte and queue the result it causes.
    function void note_byte(logic [7:0] rx);
      result_t r;
      r = '0;
      case (parse_phase)
        PH_LEN: begin
          frame_len   = rx;
          data_pos    = '0;
          data_sum    = '0;
          parse_phase = (rx == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          r.payload_byte  = rx;
          r.payload_index = data_pos;
          r.payload_valid = 1'b1;
          data_sum        = data_sum + rx;
          data_pos        = data_pos + 8'd1;
          if (data_pos == frame_len) begin
            parse_phase = PH_CHECK;
          end
        end
        PH_CHECK: begin
          check_byte  = rx;
          parse_phase = PH_END;
        end
        PH_END: begin
          // A wrong end marker wins over a checksum mismatch.
          if (rx != end_marker) begin
            r.frame_status = ST_BAD_END;
          end else if (data_sum != check_byte) begin
            r.frame_status = ST_BAD_SUM;
          end else begin
            r.frame_status = ST_GOOD;
          end
          r.frame_length = frame_len;
          parse_phase    = PH_WAIT;
        end
        default: begin
          parse_phase = (rx == start_marker) ? PH_LEN : PH_WAIT;
        end
      endcase
      expected_q.push_back(r);
      bytes_noted++;
    endfunction

    // Compare one accepted result beat with the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected result beat: byte %h index %0d valid %b status %0d length %0d",
                   got.payload_byte, got.payload_index, got.payload_valid,
                   got.frame_status, got.frame_length);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.payload_byte !== want.payload_byte ||
          got.payload_index !== want.payload_index ||
          got.payload_valid !== want.payload_valid ||
          got.frame_status !== want.frame_status ||
          got.frame_length !== want.frame_length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result beat %0d: expected byte %h index %0d valid %b status %0d length %0d",
                   results_seen, want.payload_byte, want.payload_index, want.payload_valid,
                   want.frame_status, want.frame_length);
          $display("       got      byte %h index %0d valid %b status %0d length %0d",
                   got.payload_byte, got.payload_index, got.payload_valid,
                   got.frame_status, got.frame_length);
        end
      end
    endfunction

  endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Feeds hand-picked and random frames, noise and broken frames through the
// receiver under several marker settings, with random gaps on both sides and
// long output stalls, and checks every result beat against a parser model.
// ----------------------------------------------------------------------------
module testbench;

  import fpr_pkg::*;
  import fpr_scoreboard_pkg::*;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 150;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;
  logic                 rx_valid  = 1'b0;
  logic                 rx_ready;
  logic [7:0]           rx_byte   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           payload_byte;
  logic [7:0]           payload_index;
  logic                 payload_valid;
  logic [1:0]           frame_status;
  logic [7:0]           frame_length;

  frame_scoreboard sb = new();
  bit              src_burst = 1'b0;

  framed_packet_receiver_checksum_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_valid      (rx_valid),
    .rx_ready      (rx_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .payload_valid (payload_valid),
    .frame_status  (frame_status),
    .frame_length  (frame_length)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one byte beat after a random gap and hold it until it is taken.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= value;
    @(posedge clk);
    while (rx_ready !== 1'b1) @(posedge clk);
    sb.note_byte(value);
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic wait_drained();
    rx_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Program both markers, then poke an unused index that must be ignored.
  task automatic write_markers(input logic [7:0] start_val, input logic [7:0] end_val);
    logic [CFG_IDX_W-1:0] spare;
    logic [7:0]           junk;
    spare = ($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI;
    junk  = 8'($urandom_range(0, 255));
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_MARKER;
    cfg_data  <= start_val;
    @(posedge clk);
    sb.set_marker(CFG_START_MARKER, start_val);
    cfg_index <= CFG_END_MARKER;
    cfg_data  <= end_val;
    @(posedge clk);
    sb.set_marker(CFG_END_MARKER, end_val);
    cfg_index <= spare;
    cfg_data  <= junk;
    @(posedge clk);
    sb.set_marker(spare, junk);
    cfg_we <= 1'b0;
  endtask

  // One random frame: mostly well formed with short data, some with a bad
  // checksum or end marker, plus stray noise and frames cut short.
  task automatic send_frame();
    int unsigned kind;
    int unsigned size_sel;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  sum;
    logic [7:0]  data;
    logic [7:0]  closer;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 7) == 0) begin
      src_burst = !src_burst;
    end
    if (kind < 10) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    size_sel = $urandom_range(0, 99);
    if (size_sel < 2) begin
      len = 255;
    end else if (size_sel < 12) begin
      len = $urandom_range(9, 64);
    end else begin
      len = $urandom_range(0, 8);
    end
    send_byte(sb.start_marker);
    send_byte(len[7:0]);
    if (kind < 16) begin
      cut = $urandom_range(0, len);
      repeat (cut) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    sum = '0;
    repeat (len) begin
      data = 8'($urandom_range(0, 255));
      sum  = sum + data;
      send_byte(data);
    end
    if ($urandom_range(0, 6) == 0) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    send_byte(sum);
    closer = sb.end_marker;
    if ($urandom_range(0, 6) == 0) begin
      closer = closer ^ 8'($urandom_range(1, 255));
    end
    send_byte(closer);
  endtask

  // Result side: random back-pressure, bursts of full speed, and a few long
  // hold-offs so the block fills up and stalls its input.
  initial begin
    int unsigned gap;
    int unsigned next_hold;
    bit          sink_burst;
    result_t     seen;
    next_hold  = 120;
    sink_burst = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = sink_burst ? 0 : $urandom_range(0, 16);
      if (sb.results_seen >= next_hold) begin
        gap       = HOLD_CYCLES;
        next_hold = next_hold + 300;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      seen.payload_byte  = payload_byte;
      seen.payload_index = payload_index;
      seen.payload_valid = payload_valid;
      seen.frame_status  = frame_status;
      seen.frame_length  = frame_length;
      sb.check_result(seen);
      if ($urandom_range(0, 31) == 0) begin
        sink_burst = !sink_burst;
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((rx_valid === 1'b1 && rx_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence.
  initial begin
    logic [7:0]  opening_seq[$];
    logic [7:0]  start_val;
    logic [7:0]  end_val;
    int unsigned target;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Hand-picked bytes at the reset markers: noise while waiting, a good
    // frame with extreme data and a wrapping sum, an empty frame with a bad
    // checksum, a bad end marker on top of a bad checksum, and start markers
    // used as length and data bytes.
    opening_seq = '{8'h00, 8'hFF,
                    8'h02, 8'h03, 8'hFF, 8'h01, 8'h80, 8'h80, 8'h03,
                    8'h02, 8'h00, 8'hAA, 8'h03,
                    8'h02, 8'h00, 8'h11, 8'hFF,
                    8'h02, 8'h02, 8'h02, 8'h03, 8'h05, 8'h03};
    foreach (opening_seq[i]) begin
      send_byte(opening_seq[i]);
    end

    // Random frames under several marker settings, extremes first.
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: begin
          start_val = 8'h00;
          end_val   = 8'hFF;
        end
        1: begin
          start_val = 8'hFF;
          end_val   = 8'h00;
        end
        2: begin
          start_val = 8'($urandom_range(0, 255));
          end_val   = 8'($urandom_range(0, 255));
        end
        default: begin
          start_val = START_MARKER_RST;
          end_val   = END_MARKER_RST;
        end
      endcase
      write_markers(start_val, end_val);
      target = sb.bytes_noted + 180;
      while (sb.bytes_noted < target) send_frame();
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
